### design/mlp_pkg.sv
// Shared constants, types and the sigmoid table for the sigmoid network block.
package mlp_pkg;

   // network shape
   localparam int IN_CNT  = 3;
   localparam int H1_CNT  = 4;
   localparam int H2_CNT  = 4;
   localparam int OFS_HH  = IN_CNT * H1_CNT;
   localparam int OFS_HO  = OFS_HH + H1_CNT * H2_CNT;
   localparam int W_CNT   = OFS_HO + H2_CNT;
   localparam int W_AW    = (W_CNT > 1) ? $clog2(W_CNT) : 1;

   localparam int MAX_DIM = (IN_CNT > H1_CNT) ?
                            ((IN_CNT > H2_CNT) ? IN_CNT : H2_CNT) :
                            ((H1_CNT > H2_CNT) ? H1_CNT : H2_CNT);
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int X_IW    = (IN_CNT > 1) ? $clog2(IN_CNT) : 1;
   localparam int H1_IW   = (H1_CNT > 1) ? $clog2(H1_CNT) : 1;
   localparam int H2_IW   = (H2_CNT > 1) ? $clog2(H2_CNT) : 1;

   // field widths
   localparam int IDX_W   = 5;
   localparam int Q_W     = 16;
   localparam int SIG_W   = 13;
   localparam int OPA_W   = Q_W + 1;
   localparam int PROD_W  = OPA_W + Q_W;
   localparam int ACC_W   = PROD_W + $clog2(MAX_DIM + 1);
   localparam int FRAC_W  = 12;

   localparam int SIG_DEPTH = 256;
   localparam int SIG_MID   = SIG_DEPTH / 2;

   typedef logic [SIG_W-1:0] sig_rom_type [0:SIG_DEPTH-1];

   // Entry k is sigmoid(-8 + k/16) in Q0.12; exp(-m/16) is built up in Q0.32
   // by repeated multiplication, and the quotient by shift and subtract.
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type      rom;
      logic [SIG_W-1:0] neg [0:SIG_MID];
      logic [95:0]      p;
      logic [95:0]      den;
      logic [95:0]      num;
      logic [SIG_W-1:0] q;
      p = 96'd1 << 32;
      for (int m = 0; m <= SIG_MID; m++) begin
         den = (96'd1 << 32) + p;
         num = (p << 12) + (den >> 1);
         q   = '0;
         for (int b = SIG_W - 1; b >= 0; b--) begin
            if (num >= (den << b)) begin
               num  = num - (den << b);
               q[b] = 1'b1;
            end
         end
         neg[m] = q;
         p = (p * 96'd4034748383 + (96'd1 << 31)) >> 32;
      end
      for (int k = 0; k < SIG_DEPTH; k++) begin
         if (k <= SIG_MID)
            rom[k] = neg[SIG_MID - k];
         else
            rom[k] = SIG_W'(4096) - neg[k - SIG_MID];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

### design/mlp_sigmoid_inference.sv
// Sigmoid network inference: weight store, shared multiply-accumulate and sequencer.
//
//  port group     dir   handshake            contents
//  req_*          in    start & !busy        write one weight or run one inference
//  rsp_*          out   rsp_valid (1 cycle)  prediction, Q0.12
//
// A weight write completes in the accept cycle; busy stays low.
// An inference runs one multiply-accumulate per weight through the single
// multiplier, then drain, saturate and table lookup for each of the nine
// neurons. busy is high meanwhile.
// The result strobe lasts one cycle and cannot be held off.
// Synchronous reset returns the sequencer to idle; the weight store is not cleared.
module mlp_sigmoid_inference (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [mlp_pkg::IDX_W-1:0]          req_weight_index,
   input  logic signed [mlp_pkg::Q_W-1:0]     req_weight_value,
   input  logic signed [mlp_pkg::Q_W-1:0]     req_in_a,
   input  logic signed [mlp_pkg::Q_W-1:0]     req_in_b,
   input  logic signed [mlp_pkg::Q_W-1:0]     req_in_c,
   output logic                               rsp_valid,
   output logic [mlp_pkg::SIG_W-1:0]          rsp_prediction
);
   import mlp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SAT   = 3'd3;
   localparam logic [2:0] ST_SIG   = 3'd4;

   localparam logic [1:0] LY_IN    = 2'd0;
   localparam logic [1:0] LY_HID   = 2'd1;
   localparam logic [1:0] LY_OUT   = 2'd2;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

   logic [2:0]               state_ff, state_in;
   logic [1:0]               layer_ff, layer_in;
   logic [CNT_W-1:0]         neuron_ff, neuron_in;
   logic [CNT_W-1:0]         term_ff, term_in;
   logic [W_AW-1:0]          addr_ff, addr_in;
   logic                     rd_vld_ff, prod_vld_ff;
   logic                     rsp_valid_ff;
   logic [SIG_W-1:0]         rsp_pred_ff;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [OPA_W-1:0]  opa_ff;
   logic signed [Q_W-1:0]    wdata_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [Q_W-1:0]    sat_ff;

   logic signed [Q_W-1:0]    x_ff  [IN_CNT];
   logic [SIG_W-1:0]         h1_ff [H1_CNT];
   logic [SIG_W-1:0]         h2_ff [H2_CNT];
   logic [Q_W-1:0]           wmem  [W_CNT];

   logic                     accept, infer, wr_en;
   logic                     issue, acc_clr, last_out;
   logic [CNT_W-1:0]         last_term, last_neuron;
   logic [W_AW-1:0]          stride, base_cur, base_next;
   logic signed [OPA_W-1:0]  opa_sel;
   logic signed [ACC_W-1:0]  acc_scaled;
   logic [SIG_W-1:0]         sig_val;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign infer  = accept & req_type;
   assign wr_en  = accept & ~req_type & (32'(req_weight_index) < W_CNT);

   // per-layer shape
   always_comb begin
      case (layer_ff)
         LY_IN: begin
            last_term   = CNT_W'(IN_CNT - 1);
            last_neuron = CNT_W'(H1_CNT - 1);
            stride      = W_AW'(H1_CNT);
            base_cur    = '0;
            base_next   = W_AW'(OFS_HH);
            opa_sel     = OPA_W'(x_ff[term_ff[X_IW-1:0]]);
         end
         LY_HID: begin
            last_term   = CNT_W'(H1_CNT - 1);
            last_neuron = CNT_W'(H2_CNT - 1);
            stride      = W_AW'(H2_CNT);
            base_cur    = W_AW'(OFS_HH);
            base_next   = W_AW'(OFS_HO);
            opa_sel     = $signed({4'b0, h1_ff[term_ff[H1_IW-1:0]]});
         end
         default: begin
            last_term   = CNT_W'(H2_CNT - 1);
            last_neuron = '0;
            stride      = W_AW'(1);
            base_cur    = W_AW'(OFS_HO);
            base_next   = '0;
            opa_sel     = $signed({4'b0, h2_ff[term_ff[H2_IW-1:0]]});
         end
      endcase
   end

   // floor scaling then saturation to Q4.12
   assign acc_scaled = acc_ff >>> FRAC_W;
   assign sig_val    = SIG_ROM[{~sat_ff[Q_W-1], sat_ff[Q_W-2:Q_W-8]}];
   assign last_out   = (state_ff == ST_SIG) && (layer_ff == LY_OUT);

   always_comb begin
      state_in  = state_ff;
      layer_in  = layer_ff;
      neuron_in = neuron_ff;
      term_in   = term_ff;
      addr_in   = addr_ff;
      issue     = 1'b0;
      acc_clr   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (infer) begin
               state_in  = ST_MAC;
               layer_in  = LY_IN;
               neuron_in = '0;
               term_in   = '0;
               addr_in   = '0;
               acc_clr   = 1'b1;
            end
         end
         ST_MAC: begin
            issue   = 1'b1;
            addr_in = addr_ff + stride;
            term_in = term_ff + CNT_W'(1);
            if (term_ff == last_term) begin
               term_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff)
               state_in = ST_SAT;
         end
         ST_SAT: begin
            state_in = ST_SIG;
         end
         ST_SIG: begin
            acc_clr = 1'b1;
            if (neuron_ff == last_neuron) begin
               neuron_in = '0;
               if (layer_ff == LY_OUT) begin
                  state_in = ST_IDLE;
               end else begin
                  layer_in = layer_ff + 2'd1;
                  addr_in  = base_next;
                  state_in = ST_MAC;
               end
            end else begin
               neuron_in = neuron_ff + CNT_W'(1);
               addr_in   = base_cur + W_AW'(neuron_in);
               state_in  = ST_MAC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         layer_ff     <= LY_IN;
         neuron_ff    <= '0;
         term_ff      <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         neuron_ff    <= neuron_in;
         term_ff      <= term_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= issue;
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= last_out;
      end
   end

   // weight store
   always_ff @(posedge clock) begin
      if (wr_en)
         wmem[W_AW'(req_weight_index)] <= req_weight_value;
      if (issue)
         wdata_ff <= $signed(wmem[addr_ff]);
   end

   // datapath
   always_ff @(posedge clock) begin
      if (infer) begin
         for (int i = 0; i < IN_CNT; i++) begin
            if (i == 0)
               x_ff[i] <= req_in_a;
            else if (i == 1)
               x_ff[i] <= req_in_b;
            else if (i == 2)
               x_ff[i] <= req_in_c;
            else
               x_ff[i] <= '0;
         end
      end
      if (issue)
         opa_ff <= opa_sel;
      if (rd_vld_ff)
         prod_ff <= opa_ff * wdata_ff;
      if (acc_clr)
         acc_ff <= '0;
      else if (prod_vld_ff)
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (state_ff == ST_SAT) begin
         if (acc_scaled > SAT_HI)
            sat_ff <= Q_W'(32767);
         else if (acc_scaled < SAT_LO)
            sat_ff <= Q_W'(-32768);
         else
            sat_ff <= acc_scaled[Q_W-1:0];
      end
      if (state_ff == ST_SIG) begin
         if (layer_ff == LY_IN)
            h1_ff[neuron_ff[H1_IW-1:0]] <= sig_val;
         else if (layer_ff == LY_HID)
            h2_ff[neuron_ff[H2_IW-1:0]] <= sig_val;
      end
      if (last_out)
         rsp_pred_ff <= sig_val;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;

endmodule

### verif/testbench.sv
// Self-checking testbench for the sigmoid network inference block.
`timescale 1ns / 1ps

module testbench;
   import mlp_pkg::*;

   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_INFER    = 1'b1;
   localparam int   STALL_LIMIT = 2000;
   localparam int   DRAIN_WAIT  = 100;
   localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 16'sh8000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_type = OP_WRITE;
   logic [IDX_W-1:0]        req_weight_index = '0;
   logic signed [Q_W-1:0]   req_weight_value = '0;
   logic signed [Q_W-1:0]   req_in_a = '0;
   logic signed [Q_W-1:0]   req_in_b = '0;
   logic signed [Q_W-1:0]   req_in_c = '0;
   logic                    rsp_valid;
   logic [SIG_W-1:0]        rsp_prediction;

   logic signed [Q_W-1:0]   weight_shadow [0:W_CNT-1];
   logic [SIG_W-1:0]        sig_lut [0:SIG_DEPTH-1];
   logic [SIG_W-1:0]        pending_predictions [$];
   logic [SIG_W-1:0]        want_prediction;
   int                      mismatch_count = 0;
   int                      idle_cycles = 0;

   mlp_sigmoid_inference i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_in_a         (req_in_a),
      .req_in_b         (req_in_b),
      .req_in_c         (req_in_c),
      .rsp_valid        (rsp_valid),
      .rsp_prediction   (rsp_prediction)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // sigmoid table: exp(-m/16) built up in Q0.32, then rounded divide
   initial begin : sigmoid_fill
      bit [63:0]        p;
      bit [63:0]        den;
      logic [SIG_W-1:0] neg_half [0:SIG_MID];
      p = 64'd1 << 32;
      for (int m = 0; m <= SIG_MID; m++) begin
         den         = (64'd1 << 32) + p;
         neg_half[m] = SIG_W'((64'd4096 * p + (den >> 1)) / den);
         p           = (p * 64'd4034748383 + (64'd1 << 31)) >> 32;
      end
      for (int k = 0; k < SIG_DEPTH; k++) begin
         if (k <= SIG_MID)
            sig_lut[k] = neg_half[SIG_MID - k];
         else
            sig_lut[k] = SIG_W'(4096) - neg_half[k - SIG_MID];
      end
   end

   // floor to Q4.12, saturate, table lookup
   function automatic logic [SIG_W-1:0] activate(input longint acc);
      longint s;
      s = acc >>> FRAC_W;
      if (s > 32767)
         s = 32767;
      else if (s < -32768)
         s = -32768;
      return sig_lut[int'((s + 32768) >> 8)];
   endfunction

   function automatic logic [SIG_W-1:0] net_output(input logic signed [Q_W-1:0] a, b, c);
      longint x [IN_CNT];
      longint h1 [H1_CNT];
      longint h2 [H2_CNT];
      longint acc;
      for (int j = 0; j < IN_CNT; j++)
         x[j] = (j == 0) ? a : (j == 1) ? b : (j == 2) ? c : 0;
      for (int i = 0; i < H1_CNT; i++) begin
         acc = 0;
         for (int j = 0; j < IN_CNT; j++)
            acc += x[j] * longint'(weight_shadow[j * H1_CNT + i]);
         h1[i] = activate(acc);
      end
      for (int i = 0; i < H2_CNT; i++) begin
         acc = 0;
         for (int j = 0; j < H1_CNT; j++)
            acc += h1[j] * longint'(weight_shadow[OFS_HH + j * H2_CNT + i]);
         h2[i] = activate(acc);
      end
      acc = 0;
      for (int j = 0; j < H2_CNT; j++)
         acc += h2[j] * longint'(weight_shadow[OFS_HO + j]);
      return activate(acc);
   endfunction

   // extremes, full-range random and small values, so the network does not always sit in saturation
   function automatic logic signed [Q_W-1:0] pick_q();
      case ($urandom_range(0, 7))
         0: return Q_MAX;
         1: return Q_MIN;
         2, 3, 4: return Q_W'($urandom);
         default: return Q_W'(int'($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   // present one item, hold it until accepted, then update the shadow model
   task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic signed [Q_W-1:0] wval, a, b, c,
                            input bit gaps);
      start            <= 1'b1;
      req_type         <= kind;
      req_weight_index <= idx;
      req_weight_value <= wval;
      req_in_a         <= a;
      req_in_b         <= b;
      req_in_c         <= c;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      if (kind == OP_WRITE) begin
         if (idx < W_CNT)
            weight_shadow[idx] = wval;
      end else begin
         pending_predictions = {pending_predictions, net_output(a, b, c)};
      end
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // all weights at the positive extreme, inputs at both extremes and zero
   task automatic test_extreme_weights();
      for (int s = 0; s < W_CNT; s++)
         send_item(OP_WRITE, IDX_W'(s), Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1);
      send_item(OP_INFER, '1, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1);
      send_item(OP_INFER, '0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0);
      send_item(OP_INFER, '1, '0, '0, '0, '0, 1'b1);
   endtask

   // first layer flipped negative, last weight negative: saturation low
   task automatic test_negative_weights();
      for (int s = 0; s < OFS_HH; s++)
         send_item(OP_WRITE, IDX_W'(s), Q_MIN, '0, '0, '0, 1'b0);
      send_item(OP_INFER, '0, '0, Q_MAX, Q_MAX, Q_MAX, 1'b0);
      send_item(OP_INFER, '0, '0, Q_MAX, Q_MIN, '0, 1'b1);
      send_item(OP_WRITE, IDX_W'(W_CNT - 1), Q_MIN, '0, '0, '0, 1'b1);
      send_item(OP_INFER, '1, '1, 16'sd4096, -16'sd4096, 16'sd1, 1'b1);
      send_item(OP_INFER, '1, '1, '0, '0, '0, 1'b0);
   endtask

   // weight updates interleaved with inference; weight fields on inference are noise
   task automatic test_random_traffic(input int count, input bit gaps);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 55)
            send_item(OP_WRITE, IDX_W'($urandom), pick_q(), pick_q(), pick_q(), pick_q(),
                      gaps);
         else
            send_item(OP_INFER, IDX_W'($urandom), Q_W'($urandom), pick_q(), pick_q(),
                      pick_q(), gaps);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_predictions.size() == 0) begin
            $display("%0t: unexpected prediction, expected none, got %0d",
                     $time, rsp_prediction);
            mismatch_count++;
         end else begin
            want_prediction = pending_predictions.pop_front();
            if (rsp_prediction !== want_prediction) begin
               $display("%0t: prediction mismatch, expected %0d, got %0d",
                        $time, want_prediction, rsp_prediction);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_weights();
      test_negative_weights();
      test_random_traffic(600, 1'b1);
      test_random_traffic(250, 1'b0);
      test_random_traffic(450, 1'b1);
      test_random_traffic(150, 1'b0);
      start <= 1'b0;
      while (pending_predictions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
